/* design/indexed_array_insert_delete_search_top_assert.svh */
// assertion macros for the indexed array store
// no dependencies; included by the top level
`ifndef INDEXED_ARRAY_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH
`define INDEXED_ARRAY_INSERT_DELETE_SEARCH_TOP_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define IAIDS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("iaids: same-cycle check failed");

// condition in this cycle implies consequence in the next cycle
`define IAIDS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("iaids: next-cycle check failed");

`endif

/* design/iaids_pkg.sv */
// shared types and constants for the indexed array store
// no dependencies
package iaids_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int OP_W      = 3;
    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int FILL_W    = 7;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef logic [OP_W-1:0]   opcode_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam opcode_t OP_READ   = 3'd0;
    localparam opcode_t OP_INSERT = 3'd1;
    localparam opcode_t OP_DELETE = 3'd2;
    localparam opcode_t OP_SEARCH = 3'd3;
    localparam opcode_t OP_UPDATE = 3'd4;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_RANGE    = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_NOTFOUND = 2'd3;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic                    upd;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } cell_ctrl_t;

endpackage

/* design/iaids_cell.sv */
// one storage cell of the element chain: holds one element, shifts to/from neighbours
// depends on iaids_pkg
module iaids_cell
    import iaids_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                    aclk,
    input  cell_ctrl_t              ctrl,
    input  logic [CW-1:0]           count,
    input  logic signed [VAL_W-1:0] left_elem,
    input  logic signed [VAL_W-1:0] right_elem,
    output logic signed [VAL_W-1:0] elem,
    output logic                    match,
    output logic signed [VAL_W-1:0] rd_data
);

    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic signed [VAL_W-1:0] elem_reg;
    logic signed [VAL_W-1:0] elem_next;
    logic [XW-1:0]           idx_x;
    logic [XW-1:0]           pos_x;
    logic [XW-1:0]           cnt_x;
    logic                    at_pos;

    assign idx_x  = XW'(IDX);
    assign pos_x  = XW'(ctrl.position);
    assign cnt_x  = XW'(count);
    assign at_pos = (idx_x == pos_x);

    always_comb begin
        elem_next = elem_reg;
        if (ctrl.ins) begin
            if (idx_x > pos_x && idx_x <= cnt_x) begin
                elem_next = left_elem;
            end else if (at_pos) begin
                elem_next = ctrl.value;
            end
        end else if (ctrl.del) begin
            if (idx_x >= pos_x && (idx_x + XW'(1)) < cnt_x) begin
                elem_next = right_elem;
            end
        end else if (ctrl.upd && at_pos) begin
            elem_next = ctrl.value;
        end
    end

    always_ff @(posedge aclk) begin
        elem_reg <= elem_next;
    end

    assign elem    = elem_reg;
    assign match   = (idx_x < cnt_x) && (elem_reg == ctrl.value);
    assign rd_data = at_pos ? elem_reg : '0;

endmodule

/* design/iaids_prio.sv */
// lowest-set-bit priority encoder over the cell match lines
// depends on iaids_pkg
module iaids_prio
    import iaids_pkg::*;
#(
    parameter int N  = DEPTH_DEF,
    parameter int IW = 6
) (
    input  logic [N-1:0]  req,
    output logic [IW-1:0] idx,
    output logic          any
);

    logic [N-1:0] onehot;

    // isolate lowest set bit
    assign onehot = req & (~req + N'(1));
    assign any    = |req;

    always_comb begin
        idx = '0;
        for (int i = 0; i < N; i++) begin
            if (onehot[i]) begin
                idx = idx | IW'(i);
            end
        end
    end

endmodule

/* design/indexed_array_insert_delete_search_top.sv */
// top level of the indexed array store: controller, cell chain, encoder, output register
// depends on iaids_pkg, iaids_cell, iaids_prio and the assertion macro header
//
// usage
// - s_ channel carries one command item: opcode, position, value
// - m_ channel returns exactly one result item per command: status,
//   found_position, read_data, fill_count after the command
// - the elements sit in a row of DEPTH cells; insert and delete shift every
//   affected cell by one place towards its neighbour at once, search
//   compares all cells at once and a priority encoder picks the lowest hit
// - an accepted item goes through the cell update, then the encode into
//   the output register, where its result becomes valid
// - one item at a time, set by the three-step sequence through the cell
//   row and the encoder; s_tready is high in the idle step
// - a finished result waits in the output register, and the next item is
//   accepted meanwhile; if m_tready stays low the following item waits in
//   the encode step until the output register is free
// - reset: fill count cleared, array empty; cell contents are left as they
//   are and never read before being written, so no clearing pass is needed
`include "indexed_array_insert_delete_search_top_assert.svh"

module indexed_array_insert_delete_search_top
    import iaids_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // opcode[2:0], position[8:3], value[40:9]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status[1:0], found_position[7:2],
                                            // read_data[39:8], fill_count[46:40]
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_EXEC,
        PH_ENC
    } phase_t;

    // control state
    phase_t                  phase_reg, phase_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    out_valid_reg, out_valid_next;

    // command and intermediate payload
    opcode_t                 op_reg, op_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    status_t                 stat_reg, stat_next;
    logic                    srch_reg, srch_next;
    logic [DEPTH-1:0]        match_reg, match_next;
    logic signed [VAL_W-1:0] rdata_reg, rdata_next;
    logic [M_TDATA_W-1:0]    out_data_reg, out_data_next;

    // cell row wiring
    cell_ctrl_t              ctrl;
    logic signed [VAL_W-1:0] elem_w [DEPTH];
    logic signed [VAL_W-1:0] rd_w   [DEPTH];
    logic [DEPTH-1:0]        match_w;
    logic signed [VAL_W-1:0] rd_or;

    // range checks
    logic [XW-1:0]           pos_x;
    logic [XW-1:0]           cnt_x;
    logic                    in_range;
    logic                    ins_bad;
    logic                    is_full;
    logic                    exec;

    // encoder
    logic [IW-1:0]           enc_idx;
    logic                    enc_any;
    logic [IW+POS_W-1:0]     found_x;
    logic [CW+FILL_W-1:0]    fill_x;
    status_t                 res_stat;
    logic [POS_W-1:0]        res_found;

    assign exec     = (phase_reg == PH_EXEC);
    assign pos_x    = XW'(pos_reg);
    assign cnt_x    = XW'(count_reg);
    assign in_range = (pos_x < cnt_x);
    assign ins_bad  = (pos_x > cnt_x);
    assign is_full  = (cnt_x >= XW'(DEPTH));

    assign ctrl.ins      = exec && (op_reg == OP_INSERT) && !ins_bad && !is_full;
    assign ctrl.del      = exec && (op_reg == OP_DELETE) && in_range;
    assign ctrl.upd      = exec && (op_reg == OP_UPDATE) && in_range;
    assign ctrl.position = pos_reg;
    assign ctrl.value    = val_reg;

    // the chain of cells; ends see zero neighbours, never shifted in
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VAL_W-1:0] left_w;
        logic signed [VAL_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_left
            assign left_w = elem_w[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_right
            assign right_w = elem_w[g+1];
        end
        iaids_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .left_elem  (left_w),
            .right_elem (right_w),
            .elem       (elem_w[g]),
            .match      (match_w[g]),
            .rd_data    (rd_w[g])
        );
    end

    // only the addressed cell drives a non-zero read value
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or = rd_or | rd_w[i];
        end
    end

    iaids_prio #(
        .N  (DEPTH),
        .IW (IW)
    ) u_prio (
        .req (match_reg),
        .idx (enc_idx),
        .any (enc_any)
    );

    assign found_x   = (IW + POS_W)'(enc_idx);
    assign fill_x    = (CW + FILL_W)'(count_reg);
    assign res_stat  = srch_reg ? (enc_any ? ST_OK : ST_NOTFOUND) : stat_reg;
    assign res_found = (srch_reg && enc_any) ? found_x[POS_W-1:0] : '0;

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        stat_next      = stat_reg;
        srch_next      = srch_reg;
        match_next     = match_reg;
        rdata_next     = rdata_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (phase_reg)
            PH_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[2:0];
                    pos_next   = s_tdata[8:3];
                    val_next   = s_tdata[40:9];
                    phase_next = PH_EXEC;
                end
            end
            PH_EXEC: begin
                stat_next  = ST_OK;
                srch_next  = (op_reg == OP_SEARCH);
                match_next = match_w;
                rdata_next = '0;
                case (op_reg)
                    OP_READ: begin
                        if (in_range) begin
                            rdata_next = rd_or;
                        end else begin
                            stat_next = ST_RANGE;
                        end
                    end
                    OP_INSERT: begin
                        if (ins_bad) begin
                            stat_next = ST_RANGE;
                        end else if (is_full) begin
                            stat_next = ST_FULL;
                        end else begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_DELETE: begin
                        if (in_range) begin
                            count_next = count_reg - CW'(1);
                        end else begin
                            stat_next = ST_RANGE;
                        end
                    end
                    OP_UPDATE: begin
                        if (!in_range) begin
                            stat_next = ST_RANGE;
                        end
                    end
                    default: begin
                    end
                endcase
                phase_next = PH_ENC;
            end
            PH_ENC: begin
                if (!out_valid_reg || m_tready) begin
                    out_data_next  = {1'b0, fill_x[FILL_W-1:0], rdata_reg, res_found, res_stat};
                    out_valid_next = 1'b1;
                    phase_next     = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            stat_reg      <= stat_next;
            srch_reg      <= srch_next;
            match_reg     <= match_next;
            rdata_reg     <= rdata_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign s_tready = (phase_reg == PH_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    `IAIDS_ASSERT_NEXT(a_accept_to_exec, aclk, aresetn, s_tvalid && s_tready, phase_reg == PH_EXEC)
    `IAIDS_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, cnt_x <= XW'(DEPTH))
    `IAIDS_ASSERT_NEXT(a_count_only_exec, aclk, aresetn, phase_reg != PH_EXEC, $stable(count_reg))
    `IAIDS_ASSERT_IMPL(a_result_from_enc, aclk, aresetn, $rose(out_valid_reg), $past(phase_reg) == PH_ENC)

endmodule

/* bench/tb_indexed_array_insert_delete_search_top.sv */
// testbench for the indexed array store: random and directed commands with a self-checking predictor
// depends on iaids_pkg and the indexed_array_insert_delete_search_top rtl
`timescale 1ns / 1ps

module tb_indexed_array_insert_delete_search_top;
    import iaids_pkg::*;

    localparam int ARRAY_DEPTH = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 800;

    // field order puts opcode in the lowest bits, matching s_tdata
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
        opcode_t          op;
    } array_cmd_t;

    // field order puts status in the lowest bits, matching m_tdata
    typedef struct packed {
        logic [FILL_W-1:0] fill_count;
        logic [VAL_W-1:0]  read_data;
        logic [POS_W-1:0]  found_position;
        status_t           status;
    } array_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    indexed_array_insert_delete_search_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // opcode[2:0], position[8:3], value[40:9]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // status[1:0], found_position[7:2], read_data[39:8],
                                // fill_count[46:40]
    );

    always #1 aclk = ~aclk;

    // commands waiting to be driven and results still owed by the block
    array_cmd_t    pending_cmds[$];
    array_result_t expected_results[$];

    // predictor state: the element row and its fill level
    logic [VAL_W-1:0] shadow_elems[ARRAY_DEPTH];
    int               shadow_fill = 0;

    int unsigned failures = 0;
    int unsigned results_seen = 0;
    int unsigned status_hits[4] = '{0, 0, 0, 0};
    int unsigned peak_fill = 0;

    // generator bookkeeping: fill level as the command list will leave it
    int gen_fill = 0;
    int gen_total = 0;

    // works out the result of one command and moves the predictor state on
    function automatic array_result_t apply_array_command(input array_cmd_t cmd);
        array_result_t res;
        int            idx;
        res = '0;
        res.status = ST_OK;
        case (cmd.op)
            OP_READ: begin
                if (int'(cmd.position) < shadow_fill)
                    res.read_data = shadow_elems[cmd.position];
                else
                    res.status = ST_RANGE;
            end
            OP_INSERT: begin
                // range check wins over the full check
                if (int'(cmd.position) > shadow_fill) begin
                    res.status = ST_RANGE;
                end else if (shadow_fill >= ARRAY_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (idx = shadow_fill; idx > int'(cmd.position); idx--)
                        shadow_elems[idx] = shadow_elems[idx-1];
                    shadow_elems[cmd.position] = cmd.value;
                    shadow_fill++;
                end
            end
            OP_DELETE: begin
                if (int'(cmd.position) < shadow_fill) begin
                    for (idx = cmd.position; idx + 1 < shadow_fill; idx++)
                        shadow_elems[idx] = shadow_elems[idx+1];
                    shadow_fill--;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            OP_SEARCH: begin
                // lowest matching position wins
                res.status = ST_NOTFOUND;
                for (idx = 0; idx < shadow_fill; idx++) begin
                    if (res.status == ST_NOTFOUND && shadow_elems[idx] == cmd.value) begin
                        res.status = ST_OK;
                        res.found_position = idx[POS_W-1:0];
                    end
                end
            end
            OP_UPDATE: begin
                if (int'(cmd.position) < shadow_fill)
                    shadow_elems[cmd.position] = cmd.value;
                else
                    res.status = ST_RANGE;
            end
            default: begin
                // unused opcodes leave everything alone
            end
        endcase
        res.fill_count = shadow_fill[FILL_W-1:0];
        return res;
    endfunction

    // queue a command and track the fill level it leaves behind
    task automatic add_cmd(input opcode_t op, input int pos, input logic [VAL_W-1:0] val);
        array_cmd_t cmd;
        cmd.op = op;
        cmd.position = pos[POS_W-1:0];
        cmd.value = val;
        pending_cmds.push_back(cmd);
        gen_total++;
        if (op == OP_INSERT && pos <= gen_fill && gen_fill < ARRAY_DEPTH)
            gen_fill++;
        else if (op == OP_DELETE && pos < gen_fill)
            gen_fill--;
    endtask

    // small values repeat often, so searches hit and find duplicates
    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 15);
        return $urandom;
    endfunction

    // position inside the current fill, or anywhere now and then
    function automatic int pick_position(input bit for_insert);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, ARRAY_DEPTH - 1);
        if (for_insert)
            return (gen_fill >= ARRAY_DEPTH) ? $urandom_range(0, ARRAY_DEPTH - 1)
                                             : $urandom_range(0, gen_fill);
        return (gen_fill == 0) ? 0 : $urandom_range(0, gen_fill - 1);
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of items from the pending queue with random gaps
    // ------------------------------------------------------------------
    int         burst_left = 1;
    int         gap_left = 0;
    array_cmd_t next_cmd;
    array_cmd_t taken_cmd;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else begin
            // item taken by the block: predict its result now
            if (s_tvalid && s_tready) begin
                taken_cmd = s_tdata[$bits(array_cmd_t)-1:0];
                expected_results.push_back(apply_array_command(taken_cmd));
                status_hits[expected_results[$].status]++;
                if (shadow_fill > peak_fill)
                    peak_fill = shadow_fill;
            end
            // valid only drops or changes once the current item has gone
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    next_cmd = pending_cmds.pop_front();
                    s_tdata <= {{(S_TDATA_W - $bits(array_cmd_t)){1'b0}}, next_cmd};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = $urandom_range(0, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result item, and drives its own stall pattern
    // ------------------------------------------------------------------
    int unsigned   rx_cycle = 0;
    int unsigned   hold_left = 0;
    bit            hold_done = 1'b0;
    array_result_t got;
    array_result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(array_result_t)-1:0];
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected: %h", m_tdata);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        failures++;
                    end
                    if (got.found_position !== want.found_position) begin
                        $error("found_position: expected %0d, got %0d",
                               want.found_position, got.found_position);
                        failures++;
                    end
                    if (got.read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                        failures++;
                    end
                    if (got.fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d",
                               want.fill_count, got.fill_count);
                        failures++;
                    end
                end
            end
            rx_cycle++;
            // one long hold-off mid run, so the block backs up into the sender
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_seen >= 300) begin
                hold_done = 1'b1;
                hold_left = 400;
                m_tready <= 1'b0;
            end else begin
                // four stall moods, chosen by bits 8:7 of the cycle counter
                case (rx_cycle[8:7])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= ($urandom_range(0, 1) == 0);
                    2'd2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= (rx_cycle[2:0] != 3'd5);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    int seq_kind;
    int seq_len;
    int pick;
    int mixed_pos;

    initial begin
        // empty array: every access out of range, search misses
        add_cmd(OP_SEARCH, 0, 32'd0);
        add_cmd(OP_READ, 0, 32'd0);
        add_cmd(OP_DELETE, 0, 32'd0);
        add_cmd(OP_UPDATE, 0, 32'h1234_5678);
        add_cmd(OP_INSERT, 1, 32'd9);              // insert beyond the fill
        // build up with extreme values, front, middle and append
        add_cmd(OP_INSERT, 0, 32'h8000_0000);
        add_cmd(OP_INSERT, 1, 32'h7FFF_FFFF);
        add_cmd(OP_INSERT, 0, 32'd0);
        add_cmd(OP_INSERT, 1, 32'hFFFF_FFFF);
        add_cmd(OP_READ, 3, 32'd0);
        add_cmd(OP_READ, 4, 32'd0);                // one past the end
        add_cmd(OP_READ, 63, 32'hFFFF_FFFF);
        add_cmd(OP_SEARCH, 0, 32'h7FFF_FFFF);
        add_cmd(OP_SEARCH, 0, 32'd5);
        add_cmd(OP_UPDATE, 2, 32'd5);
        add_cmd(OP_INSERT, 2, 32'd5);              // duplicate, first match counts
        add_cmd(OP_SEARCH, 63, 32'd5);
        add_cmd(OP_DELETE, 4, 32'd0);              // last element
        add_cmd(OP_DELETE, 0, 32'd0);              // first element
        add_cmd(OP_DELETE, 1, 32'd0);              // middle element
        add_cmd(3'd5, 63, 32'hFFFF_FFFF);          // unused opcodes
        add_cmd(3'd6, 0, 32'd0);
        add_cmd(3'd7, 21, 32'hA5A5_A5A5);
        add_cmd(OP_UPDATE, 2, 32'd1);              // update at the fill level

        // random part made of short sequences
        while (gen_total < RANDOM_ITEMS + 24) begin
            seq_kind = $urandom_range(0, 9);
            if (seq_kind <= 2) begin
                // fill to the top, then knock on a full array
                while (gen_fill < ARRAY_DEPTH)
                    add_cmd(OP_INSERT, $urandom_range(0, gen_fill), pick_value());
                repeat ($urandom_range(1, 3))
                    add_cmd(OP_INSERT, $urandom_range(0, ARRAY_DEPTH - 1), pick_value());
                add_cmd(OP_READ, ARRAY_DEPTH - 1, pick_value());
            end else if (seq_kind <= 4) begin
                // drain a stretch
                repeat ($urandom_range(5, 30))
                    add_cmd(OP_DELETE, pick_position(1'b0), pick_value());
            end else if (seq_kind <= 8) begin
                // mixed traffic at mostly valid positions
                seq_len = $urandom_range(10, 30);
                repeat (seq_len) begin
                    pick = $urandom_range(0, 19);
                    if (pick <= 3)
                        add_cmd(OP_READ, pick_position(1'b0), pick_value());
                    else if (pick <= 7)
                        add_cmd(OP_INSERT, pick_position(1'b1), pick_value());
                    else if (pick <= 10)
                        add_cmd(OP_DELETE, pick_position(1'b0), pick_value());
                    else if (pick <= 14)
                        add_cmd(OP_SEARCH, $urandom_range(0, ARRAY_DEPTH - 1), pick_value());
                    else if (pick <= 17)
                        add_cmd(OP_UPDATE, pick_position(1'b0), pick_value());
                    else if (pick == 18)
                        add_cmd(opcode_t'($urandom_range(5, 7)),
                                $urandom_range(0, ARRAY_DEPTH - 1), $urandom);
                    else begin
                        mixed_pos = $urandom_range(0, ARRAY_DEPTH - 1);
                        add_cmd(opcode_t'($urandom_range(0, 4)), mixed_pos, $urandom);
                    end
                end
            end else begin
                // noise: anything at all
                repeat ($urandom_range(5, 10))
                    add_cmd(opcode_t'($urandom_range(0, 7)),
                            $urandom_range(0, ARRAY_DEPTH - 1), $urandom);
            end
        end

        // reset held low from the start, released once
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // all items handed over, then all results back, then a short tail
        while (pending_cmds.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);

        $display("ran %0d commands, %0d results: ok %0d, range %0d, full %0d, not found %0d",
                 gen_total, results_seen, status_hits[ST_OK], status_hits[ST_RANGE],
                 status_hits[ST_FULL], status_hits[ST_NOTFOUND]);
        $display("highest fill level reached %0d of %0d", peak_fill, ARRAY_DEPTH);
        if (failures == 0) begin
            $display("[indexed_array_insert_delete_search_top] OK");
        end else begin
            $display("[indexed_array_insert_delete_search_top] ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #400000;
        $display("[indexed_array_insert_delete_search_top] ERROR");
        $finish;
    end

endmodule
